// ===== rtl/core/look_at_view_basis_macros.svh =====
// assertion macros for the view basis block
`ifndef LOOK_AT_VIEW_BASIS_MACROS_SVH
`define LOOK_AT_VIEW_BASIS_MACROS_SVH

// assert that a property holds, reporting by error
`define LVB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert an implication on the next cycle
`define LVB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/lvb_pkg.sv =====
package lvb_pkg;

  localparam int unsigned CompW   = 32;
  localparam int unsigned NumIn   = 9;
  localparam int unsigned NumOut  = 12;
  localparam int unsigned InW     = CompW * NumIn;
  localparam int unsigned OutW    = CompW * NumOut;
  // root and divide stages of one normalizer
  localparam int unsigned IsqrtSteps = 32;
  localparam int unsigned DivSteps   = 32;

  typedef logic signed [63:0] vec_t [3];

endpackage

// ===== rtl/core/lvb_normalize.sv =====
// pipelined normalizer: magnitudes, scale, square sum, restoring square root, restoring divide
// one root bit and one quotient bit per stage; stages: magnitude, shift, square sum, root steps, divide steps, output
module lvb_normalize (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [63:0]  v_x_i,
  input  logic signed [63:0]  v_y_i,
  input  logic signed [63:0]  v_z_i,
  output logic signed [31:0]  n_x_o,
  output logic signed [31:0]  n_y_o,
  output logic signed [31:0]  n_z_o
);
  localparam int unsigned NS = lvb_pkg::IsqrtSteps;
  localparam int unsigned ND = lvb_pkg::DivSteps;

  // stage a: magnitudes
  logic [62:0] mag_d [3];
  logic [62:0] mag_q [3];
  logic [2:0]  neg_d;
  logic [2:0]  mneg_q;

  always_comb begin
    mag_d[0] = v_x_i[63] ? 63'(-v_x_i) : v_x_i[62:0];
    mag_d[1] = v_y_i[63] ? 63'(-v_y_i) : v_y_i[62:0];
    mag_d[2] = v_z_i[63] ? 63'(-v_z_i) : v_z_i[62:0];
    neg_d = {v_z_i[63], v_y_i[63], v_x_i[63]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      mneg_q <= neg_d;
    end
  end

  // stage a2: common shift, largest magnitude lands in [2^30, 2^31)
  // top set bit of the or of the magnitudes is that of the largest
  logic [62:0] mor;
  logic [6:0]  bits;
  logic [30:0] a_d [3];
  logic [30:0] a_q [3];
  logic [2:0]  neg_q;
  logic        zero_q;

  always_comb begin
    mor = mag_q[0] | mag_q[1] | mag_q[2];
    bits = '0;
    for (int b = 0; b < 63; b++) begin
      if (mor[b]) bits = 7'(b + 1);
    end
    for (int i = 0; i < 3; i++) begin
      if (bits > 7'd31) a_d[i] = 31'(mag_q[i] >> (bits - 7'd31));
      else              a_d[i] = 31'({32'd0, mag_q[i]} << (7'd31 - bits));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      neg_q  <= mneg_q;
      zero_q <= (mor == '0);
    end
  end

  // stage b: sum of squares
  logic [63:0] s_q;
  logic [30:0] b_a_q [3];
  logic [2:0]  b_neg_q;
  logic        b_zero_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= 64'(a_q[0] * a_q[0]) + 64'(a_q[1] * a_q[1]) + 64'(a_q[2] * a_q[2]);
      b_a_q <= a_q;
      b_neg_q <= neg_q;
      b_zero_q <= zero_q;
    end
  end

  // square root, one result bit per stage
  logic [65:0] sr_rem_q [NS+1];
  logic [63:0] sr_n_q   [NS+1];
  logic [31:0] sr_root_q[NS+1];
  logic [30:0] sr_a_q   [NS+1][3];
  logic [2:0]  sr_neg_q [NS+1];
  logic        sr_zero_q[NS+1];

  always_comb begin
    sr_rem_q[0]  = '0;
    sr_n_q[0]    = s_q;
    sr_root_q[0] = '0;
    sr_a_q[0]    = b_a_q;
    sr_neg_q[0]  = b_neg_q;
    sr_zero_q[0] = b_zero_q;
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [65:0] rem;
    logic [65:0] trial;
    always_comb begin
      rem   = {sr_rem_q[k][63:0], sr_n_q[k][63:62]};
      trial = {32'd0, sr_root_q[k], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem >= trial) begin
          sr_rem_q[k+1]  <= rem - trial;
          sr_root_q[k+1] <= {sr_root_q[k][30:0], 1'b1};
        end else begin
          sr_rem_q[k+1]  <= rem;
          sr_root_q[k+1] <= {sr_root_q[k][30:0], 1'b0};
        end
        sr_n_q[k+1]    <= {sr_n_q[k][61:0], 2'b00};
        sr_a_q[k+1]    <= sr_a_q[k];
        sr_neg_q[k+1]  <= sr_neg_q[k];
        sr_zero_q[k+1] <= sr_zero_q[k];
      end
    end
  end

  // divide: (a << 30 + r/2) / r, three lanes, one quotient bit per stage
  logic [31:0] r;
  assign r = sr_root_q[NS];

  logic [62:0] dv_num_q [ND+1][3];
  logic [32:0] dv_rem_q [ND+1][3];
  logic [31:0] dv_quo_q [ND+1][3];
  logic [31:0] dv_r_q   [ND+1];
  logic [2:0]  dv_neg_q [ND+1];
  logic        dv_zero_q[ND+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num_q[0][i] = 63'({sr_a_q[NS][i], 30'd0}) + 63'(r >> 1);
      dv_rem_q[0][i] = '0;
      dv_quo_q[0][i] = '0;
    end
    dv_r_q[0]    = r;
    dv_neg_q[0]  = sr_neg_q[NS];
    dv_zero_q[0] = sr_zero_q[NS];
  end

  // quotient fits 32 bits, so leading 32 numerator bits seed the remainder
  for (genvar k = 0; k < ND; k++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [32:0] rem;
      always_comb begin
        if (k == 0) rem = {1'b0, dv_num_q[k][i][62:31]};
        else        rem = {dv_rem_q[k][i][31:0], dv_num_q[k][i][62]};
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (rem >= {1'b0, dv_r_q[k]}) begin
            dv_rem_q[k+1][i] <= rem - {1'b0, dv_r_q[k]};
            dv_quo_q[k+1][i] <= {dv_quo_q[k][i][30:0], 1'b1};
          end else begin
            dv_rem_q[k+1][i] <= rem;
            dv_quo_q[k+1][i] <= {dv_quo_q[k][i][30:0], 1'b0};
          end
          if (k == 0) dv_num_q[k+1][i] <= {dv_num_q[k][i][30:0], 32'd0};
          else        dv_num_q[k+1][i] <= {dv_num_q[k][i][61:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_r_q[k+1]    <= dv_r_q[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_zero_q[k+1] <= dv_zero_q[k];
      end
    end
  end

  logic signed [31:0] n_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_q[ND])       n_q[i] <= '0;
        else if (dv_neg_q[ND][i]) n_q[i] <= -$signed(dv_quo_q[ND][i]);
        else                     n_q[i] <= $signed(dv_quo_q[ND][i]);
      end
    end
  end

  assign n_x_o = n_q[0];
  assign n_y_o = n_q[1];
  assign n_z_o = n_q[2];
endmodule

// ===== rtl/core/look_at_view_basis.sv =====
// look-at view basis, streaming
// s_axis: one beat per camera, tdata = eye xyz, target xyz, up xyz (Q16.16)
// m_axis: one beat per camera, tdata = right xyz, true_up xyz, back xyz (Q1.30),
//   then negated eye xyz (Q16.16, saturated)
// throughput: one beat per cycle while the output is not stalled, items independent
// pipeline: three normalizers in series, each 3 + 32 root + 32 divide + 1 stages,
//   plus a cross product stage before the second and third
// the whole pipeline advances on one enable: it holds while m_axis_tready is low
//   and the output beat is valid, so a stall drops nothing
// s_axis_tready is high whenever the output is free or being taken
// reset clears the valid bits only; payload comes out after the pipe refills
module look_at_view_basis (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // right_x..z, true_up_x..z, back_x..z, shift_x..z
  output logic [383:0] m_axis_tdata
);
  localparam int unsigned NL = 3 + lvb_pkg::IsqrtSteps + lvb_pkg::DivSteps + 1;
  localparam int unsigned Lat = 3 * NL + 2;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld_q[Lat-1];

  logic signed [31:0] eye [3], tgt [3], up [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye[i] = s_axis_tdata[32*i +: 32];
      tgt[i] = s_axis_tdata[32*(i+3) +: 32];
      up[i]  = s_axis_tdata[32*(i+6) +: 32];
    end
  end

  // delay lines for eye shift and up
  logic signed [31:0] sh_d [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      sh_d[i] = (eye[i] == 32'sh8000_0000) ? 32'sh7fff_ffff : -eye[i];
  end
  logic signed [31:0] sh_q [Lat][3];
  logic signed [31:0] up_q [NL][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sh_q[0] <= sh_d;
      up_q[0] <= up;
      for (int k = 1; k < Lat; k++) sh_q[k] <= sh_q[k-1];
      for (int k = 1; k < NL; k++)  up_q[k] <= up_q[k-1];
    end
  end

  logic signed [63:0] back [3];
  always_comb begin
    for (int i = 0; i < 3; i++) back[i] = 64'(eye[i]) - 64'(tgt[i]);
  end

  logic signed [31:0] bn [3], rn [3], un [3];
  lvb_normalize u_nb (
    .clk_i, .en_i(en),
    .v_x_i(back[0]), .v_y_i(back[1]), .v_z_i(back[2]),
    .n_x_o(bn[0]), .n_y_o(bn[1]), .n_z_o(bn[2])
  );

  // right = up x bn
  logic signed [63:0] rt_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_q[0] <= 64'(up_q[NL-1][1] * 64'(bn[2])) - 64'(up_q[NL-1][2] * 64'(bn[1]));
      rt_q[1] <= 64'(up_q[NL-1][2] * 64'(bn[0])) - 64'(up_q[NL-1][0] * 64'(bn[2]));
      rt_q[2] <= 64'(up_q[NL-1][0] * 64'(bn[1])) - 64'(up_q[NL-1][1] * 64'(bn[0]));
    end
  end

  // back normal delayed to meet right normal
  logic signed [31:0] bn_q [NL+1][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      bn_q[0] <= bn;
      for (int k = 1; k < NL + 1; k++) bn_q[k] <= bn_q[k-1];
    end
  end

  lvb_normalize u_nr (
    .clk_i, .en_i(en),
    .v_x_i(rt_q[0]), .v_y_i(rt_q[1]), .v_z_i(rt_q[2]),
    .n_x_o(rn[0]), .n_y_o(rn[1]), .n_z_o(rn[2])
  );

  logic signed [31:0] bb [3];
  assign bb = bn_q[NL];
  logic signed [63:0] tu_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      tu_q[0] <= 64'(64'(bb[1]) * 64'(rn[2])) - 64'(64'(bb[2]) * 64'(rn[1]));
      tu_q[1] <= 64'(64'(bb[2]) * 64'(rn[0])) - 64'(64'(bb[0]) * 64'(rn[2]));
      tu_q[2] <= 64'(64'(bb[0]) * 64'(rn[1])) - 64'(64'(bb[1]) * 64'(rn[0]));
    end
  end

  logic signed [31:0] rn_q [NL+1][3];
  logic signed [31:0] bo_q [NL+1][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      rn_q[0] <= rn;
      bo_q[0] <= bb;
      for (int k = 1; k < NL + 1; k++) begin
        rn_q[k] <= rn_q[k-1];
        bo_q[k] <= bo_q[k-1];
      end
    end
  end

  lvb_normalize u_nu (
    .clk_i, .en_i(en),
    .v_x_i(tu_q[0]), .v_y_i(tu_q[1]), .v_z_i(tu_q[2]),
    .n_x_o(un[0]), .n_y_o(un[1]), .n_z_o(un[2])
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata[32*i +: 32]      = rn_q[NL][i];
      m_axis_tdata[32*(i+3) +: 32]  = un[i];
      m_axis_tdata[32*(i+6) +: 32]  = bo_q[NL][i];
      m_axis_tdata[32*(i+9) +: 32]  = sh_q[Lat-1][i];
    end
  end
endmodule

// ===== rtl/core/lvb_checker.sv =====
`include "look_at_view_basis_macros.svh"
module lvb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [383:0] m_axis_tdata
);
  logic               stall;
  logic signed [31:0] right_x;
  logic               right_ok;
  assign stall    = m_axis_tvalid && !m_axis_tready;
  assign right_x  = m_axis_tdata[31:0];
  assign right_ok = right_x <= 32'sd1073741824 && right_x >= -32'sd1073741824;

  `LVB_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, stall, m_axis_tvalid, "output beat dropped")
  `LVB_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, stall, $stable(m_axis_tdata), "stalled beat changed")
  `LVB_ASSERT(a_ready, clk_i, rst_ni, stall == !s_axis_tready, "input ready not tied to stall")
  `LVB_ASSERT(a_unit, clk_i, rst_ni, !m_axis_tvalid || right_ok, "right x out of unit range")
endmodule

bind look_at_view_basis lvb_checker u_lvb_checker (.*);

// ===== tb/sv/look_at_view_basis_tb.sv =====
`timescale 1ns / 1ps

module look_at_view_basis_tb;

  localparam int unsigned NumRandom = 930;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned Drain = 400;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [383:0] m_axis_tdata;

  look_at_view_basis u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  logic [287:0] camera_q[$];
  logic [383:0] basis_q[$];
  int unsigned  n_sent, n_recv, n_err, idle_cycles;
  bit           hold_long;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(input logic signed [63:0] v [3],
                                   output logic signed [63:0] u [3]);
    logic [63:0]  a [3];
    logic [63:0]  m, s, r, q;
    logic [127:0] num;
    int           nbits;
    m = 0;
    s = 0;
    nbits = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = mag(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (nbits < 64 && (m >> nbits) != 0) nbits++;
    for (int i = 0; i < 3; i++) begin
      if (nbits > 31) a[i] = a[i] >> (nbits - 31);
      else a[i] = a[i] << (31 - nbits);
      s = s + a[i] * a[i];
    end
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      num = ({64'd0, a[i]} << 30) + (r >> 1);
      q = 64'(num / r);
      u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
  endfunction

  function automatic void cross_prod(input logic signed [63:0] p [3],
                                     input logic signed [63:0] q [3],
                                     output logic signed [63:0] o [3]);
    o[0] = p[1] * q[2] - p[2] * q[1];
    o[1] = p[2] * q[0] - p[0] * q[2];
    o[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  function automatic logic [383:0] view_basis(input logic [287:0] cam);
    logic signed [63:0] eye [3], upv [3], back [3], bn [3], rt [3], rn [3];
    logic signed [63:0] tu [3], un [3];
    logic signed [63:0] sh;
    logic [383:0]       res;
    for (int i = 0; i < 3; i++) begin
      eye[i]  = $signed(cam[32*i +: 32]);
      back[i] = eye[i] - $signed(cam[32*(3+i) +: 32]);
      upv[i]  = $signed(cam[32*(6+i) +: 32]);
    end
    unit_vec(back, bn);
    cross_prod(upv, bn, rt);
    unit_vec(rt, rn);
    cross_prod(bn, rn, tu);
    unit_vec(tu, un);
    for (int i = 0; i < 3; i++) begin
      sh = -eye[i];
      if (sh > 64'sd2147483647) sh = 64'sd2147483647;
      res[32*i +: 32]     = rn[i][31:0];
      res[32*(3+i) +: 32] = un[i][31:0];
      res[32*(6+i) +: 32] = bn[i][31:0];
      res[32*(9+i) +: 32] = sh[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 8) - 4;
      3: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [287:0] make_cam(input logic [31:0] c [9]);
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = c[i];
    return d;
  endfunction

  initial begin
    logic [31:0] c [9];
    logic [31:0] one;
    one = 32'h0001_0000;
    // ordinary camera looking down -z, y up
    c = '{0, 0, 5 * one, 0, 0, 0, 0, one, 0};
    camera_q.insert(camera_q.size(), make_cam(c));
    // eye on target
    c = '{one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0};
    camera_q.insert(camera_q.size(), make_cam(c));
    // up parallel to back
    c = '{0, 4 * one, 0, 0, 0, 0, 0, one, 0};
    camera_q.insert(camera_q.size(), make_cam(c));
    // zero up hint
    c = '{one, 0, 0, 0, 0, 0, 0, 0, 0};
    camera_q.insert(camera_q.size(), make_cam(c));
    // most negative eye, full scale target and up
    c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    camera_q.insert(camera_q.size(), make_cam(c));
    c = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    camera_q.insert(camera_q.size(), make_cam(c));
    // tiny offsets
    c = '{1, 0, 0, 0, 0, 1, 0, 1, 0};
    camera_q.insert(camera_q.size(), make_cam(c));
    c = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 1, 0, 0};
    camera_q.insert(camera_q.size(), make_cam(c));
    for (int i = 0; i < 9; i++) c[i] = 32'hffff_ffff;
    camera_q.insert(camera_q.size(), make_cam(c));
    for (int i = 0; i < 9; i++) c[i] = 0;
    camera_q.insert(camera_q.size(), make_cam(c));
    for (int k = 0; k < NumRandom; k++) begin
      for (int i = 0; i < 9; i++) c[i] = rand_comp();
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 0; i < 3; i++) c[3 + i] = c[i];
      end
      camera_q.insert(camera_q.size(), make_cam(c));
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sender
  int unsigned tx_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_wait       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        basis_q.insert(basis_q.size(), view_basis(s_axis_tdata));
        n_sent <= n_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait != 0) begin
          s_axis_tvalid <= 1'b0;
          tx_wait <= tx_wait - 1;
        end else if (camera_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= camera_q.pop_front();
          tx_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19) * $urandom_range(0, 1);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once the pipe has plenty in flight
  int unsigned rx_wait;
  int unsigned hold_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
      hold_cnt      <= 0;
      hold_long     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        logic [383:0] exp_b;
        if (basis_q.size() == 0) begin
          if (n_err < 10) $display("unexpected beat %h", m_axis_tdata);
          n_err = n_err + 1;
        end else begin
          exp_b = basis_q.pop_front();
          for (int f = 0; f < 12; f++)
            if (exp_b[32*f +: 32] !== m_axis_tdata[32*f +: 32]) begin
              if (n_err < 10)
                $display("beat %0d field %0d: exp %h got %h", n_recv, f,
                         exp_b[32*f +: 32], m_axis_tdata[32*f +: 32]);
              n_err = n_err + 1;
            end
        end
        n_recv <= n_recv + 1;
      end
      if (!hold_long && n_sent == 300) begin
        hold_long <= 1'b1;
        hold_cnt <= 600;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready)
          rx_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19) * $urandom_range(0, 1);
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("look_at_view_basis regression: fail");
      $finish;
    end
  end

  initial begin
    n_sent = 0;
    n_recv = 0;
    n_err = 0;
    idle_cycles = 0;
    wait (rst_ni);
    wait (camera_q.size() == 0 && !s_axis_tvalid && basis_q.size() == 0);
    repeat (Drain) @(posedge clk_i);
    $display("%0d cameras sent, %0d view bases checked, incl. degenerate axes,", n_sent, n_recv);
    $display("saturated translation and a long output stall");
    if (n_err == 0 && basis_q.size() == 0) begin
      $display("look_at_view_basis regression: pass");
    end else begin
      $display("%0d mismatches", n_err);
      $display("look_at_view_basis regression: fail");
    end
    $finish;
  end

endmodule
